// File: design/dlrs_pkg.sv
`default_nettype none
package dlrs_pkg;

  localparam int IN_MAX    = 1024;
  localparam int OUT_MAX   = 64;
  localparam int FRAC_BITS = 16;
  localparam int IN_AW     = $clog2(IN_MAX);
  localparam int OUT_AW    = $clog2(OUT_MAX);
  localparam int W_AW      = IN_AW + OUT_AW;
  localparam int CNT_W     = IN_AW + 1;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 48;
  localparam int SUM_W     = ACC_W + 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int LR_W      = 16;
  localparam int STEP_W    = DATA_W + LR_W + 1;

  localparam logic [2:0] OP_WR_WEIGHT = 3'd0;
  localparam logic [2:0] OP_WR_BIAS   = 3'd1;
  localparam logic [2:0] OP_FORWARD   = 3'd2;
  localparam logic [2:0] OP_BACKWARD  = 3'd3;
  localparam logic [2:0] OP_RD_GRAD   = 3'd4;

  localparam logic [1:0] REG_RELU      = 2'd0;
  localparam logic [1:0] REG_LRATE     = 2'd1;
  localparam logic [1:0] REG_IN_COUNT  = 2'd2;
  localparam logic [1:0] REG_OUT_COUNT = 2'd3;

  localparam logic KIND_ACT  = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_FWD, S_EMIT, S_RD, S_BPREP, S_BWALK
  } state_t;

  typedef struct packed {
    logic [2:0]               operation;
    logic [9:0]               row_index;
    logic [5:0]               col_index;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic                     kind;
    logic [9:0]               index;
    logic signed [DATA_W-1:0] result_value;
    logic                     final_res;
  } out_item_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } acc_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sd2147483647);
    lo = SUM_W'(-64'sd2147483648);
    if (v > hi) return DATA_W'(hi);
    else if (v < lo) return DATA_W'(lo);
    else return DATA_W'(v);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sd140737488355327);
    lo = SUM_W'(-64'sd140737488355328);
    if (v > hi) return ACC_W'(hi);
    else if (v < lo) return ACC_W'(lo);
    else return ACC_W'(v);
  endfunction

endpackage
`default_nettype wire

// File: design/dlrs_ram.sv
`default_nettype none
module dlrs_ram #(
  parameter int AW = 6,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/dlrs_acc_cell.sv
`default_nettype none
module dlrs_acc_cell import dlrs_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire acc_ctrl_t               ctrl,
  input  wire logic signed [ACC_W-1:0] d,
  output logic signed      [ACC_W-1:0] q
);

  logic signed [ACC_W-1:0] q_r;

  // take the neighbour's value on every shift; clear at pass start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (ctrl.clr) begin
      q_r <= '0;
    end else if (ctrl.shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// File: design/dense_layer_relu_sgd_unit.sv
`default_nettype none
// Fully connected layer with optional ReLU and SGD update, Q15.16 fixed point.
// A transaction is taken when start is high and busy is low; results appear
// for one cycle each on out_item, marked by out_strobe, and the receiver cannot
// hold them off, so sample every strobe. Work per transaction: a weight or
// bias write goes straight into its memory; a forward element streams the
// weight row through one multiplier while the 64-cell accumulator ring rotates
// once, and a last element then also streams the activations out; a backward
// element passes once over the inputs through a five-stage update pipeline on
// the weight, input and gradient memories, after a clearing sweep of the input
// gradient memory on the first element of a backward pass; a gradient read
// returns one entry. After reset the block runs the same sweep with busy high.
// Configuration writes are taken at any time but belong to idle periods.
module dense_layer_relu_sgd_unit import dlrs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_strobe,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // configuration
  logic             relu_r;
  logic [LR_W-1:0]  lr_r;
  logic [10:0]      in_cnt_r;
  logic [6:0]       out_cnt_r;
  logic [CNT_W-1:0] ni;
  logic [6:0]       no;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relu_r    <= 1'b1;
      lr_r      <= 16'd66;
      in_cnt_r  <= 11'd1024;
      out_cnt_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RELU:      relu_r    <= cfg_wdata[0];
        REG_LRATE:     lr_r      <= cfg_wdata;
        REG_IN_COUNT:  in_cnt_r  <= cfg_wdata[10:0];
        REG_OUT_COUNT: out_cnt_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // clamp the active counts into 1..max
  always_comb begin
    if (in_cnt_r == '0) ni = CNT_W'(1);
    else if (in_cnt_r > 11'(IN_MAX)) ni = CNT_W'(IN_MAX);
    else ni = in_cnt_r;
    if (out_cnt_r == '0) no = 7'd1;
    else if (out_cnt_r > 7'(OUT_MAX)) no = 7'(OUT_MAX);
    else no = out_cnt_r;
  end

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fwd_open_r, fwd_open_nxt;
  logic             bwd_open_r, bwd_open_nxt;
  logic             bwd_pend_r, bwd_pend_nxt;
  in_item_t         item_r;

  logic acc;
  logic row_ok_in, col_ok_in, col_ok;

  assign busy      = (state_r != S_IDLE);
  assign acc       = start && !busy;
  assign row_ok_in = ({1'b0, in_item.row_index} < ni);
  assign col_ok_in = ({1'b0, in_item.col_index} < no);
  assign col_ok    = ({1'b0, item_r.col_index} < no);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      cnt_r      <= '0;
      fwd_open_r <= 1'b0;
      bwd_open_r <= 1'b0;
      bwd_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      fwd_open_r <= fwd_open_nxt;
      bwd_open_r <= bwd_open_nxt;
      bwd_pend_r <= bwd_pend_nxt;
    end
  end

  // hold the transaction for the whole of its work
  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= in_item;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r + CNT_W'(1);
    fwd_open_nxt = fwd_open_r;
    bwd_open_nxt = bwd_open_r;
    bwd_pend_nxt = bwd_pend_r;
    unique case (state_r)
      S_CLR: begin
        if (cnt_r == CNT_W'(IN_MAX - 1)) begin
          cnt_nxt      = '0;
          bwd_pend_nxt = 1'b0;
          if (bwd_pend_r && col_ok) state_nxt = S_BPREP;
          else state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (acc) begin
          unique case (in_item.operation)
            OP_FORWARD: begin
              fwd_open_nxt = !in_item.last;
              if (row_ok_in) state_nxt = S_FWD;
              else if (in_item.last) state_nxt = S_EMIT;
            end
            OP_BACKWARD: begin
              bwd_open_nxt = !in_item.last;
              if (!bwd_open_r) begin
                state_nxt    = S_CLR;
                bwd_pend_nxt = 1'b1;
              end else if (col_ok_in) begin
                state_nxt = S_BPREP;
              end
            end
            OP_RD_GRAD: begin
              if (row_ok_in) state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_FWD: begin
        if (cnt_r == CNT_W'(OUT_MAX + 1)) begin
          cnt_nxt   = '0;
          state_nxt = item_r.last ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (cnt_r == CNT_W'(OUT_MAX)) state_nxt = S_IDLE;
      end
      S_RD: begin
        if (cnt_r == CNT_W'(1)) state_nxt = S_IDLE;
      end
      S_BPREP: begin
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_BWALK;
        end
      end
      S_BWALK: begin
        if (cnt_r == ni + CNT_W'(3)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories
  logic              w_we, b_we, p_we, x_we, g_we;
  logic [W_AW-1:0]   w_waddr, w_raddr;
  logic [OUT_AW-1:0] b_waddr, b_raddr, p_waddr;
  logic [IN_AW-1:0]  x_waddr, x_raddr, g_waddr, g_raddr;
  logic [DATA_W-1:0] w_wdata, b_wdata, p_wdata, x_wdata, g_wdata;
  logic [DATA_W-1:0] w_rdata, b_rdata, p_rdata, x_rdata, g_rdata;

  dlrs_ram #(.AW(W_AW), .DW(DATA_W)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );
  dlrs_ram #(.AW(OUT_AW), .DW(DATA_W)) u_bias (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );
  dlrs_ram #(.AW(OUT_AW), .DW(DATA_W)) u_pre (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(item_r.col_index), .rdata(p_rdata)
  );
  dlrs_ram #(.AW(IN_AW), .DW(DATA_W)) u_input (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );
  dlrs_ram #(.AW(IN_AW), .DW(DATA_W)) u_grad (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  // accumulator ring: cell 0 is the head, the ring rotates towards it
  acc_ctrl_t               ring_ctrl;
  logic signed [ACC_W-1:0] cell_q [OUT_MAX];
  logic signed [ACC_W-1:0] head_new;
  logic signed [ACC_W-1:0] prod_s;
  logic signed [PROD_W-1:0] prod_r;
  logic                    mac_add;
  logic                    emit_v, rd_v;
  logic [CNT_W-1:0]        fj, ej;

  for (genvar k = 0; k < OUT_MAX; k++) begin : g_ring
    logic signed [ACC_W-1:0] d_in;
    if (k == OUT_MAX - 1) begin : g_tail
      assign d_in = head_new;
    end else begin : g_mid
      assign d_in = cell_q[k+1];
    end
    dlrs_acc_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctrl(ring_ctrl), .d(d_in), .q(cell_q[k])
    );
  end

  // product of the element with weight row entry, registered before the add
  always_ff @(posedge clk) begin
    prod_r <= item_r.value * $signed(w_rdata);
  end

  assign prod_s   = ACC_W'(prod_r >>> FRAC_BITS);
  assign head_new = mac_add ? sat48(SUM_W'(cell_q[0]) + SUM_W'(prod_s)) : cell_q[0];
  assign fj       = cnt_r - CNT_W'(2);
  assign ej       = cnt_r - CNT_W'(1);

  // emission value: sum plus bias, kept as pre-activation, ReLU on the way out
  logic signed [DATA_W-1:0] emit_s, emit_act;
  assign emit_s   = sat32(SUM_W'(cell_q[0]) + SUM_W'($signed(b_rdata)));
  assign emit_act = (relu_r && emit_s < 0) ? '0 : emit_s;

  // backward datapath
  logic signed [DATA_W-1:0] dz_r, bh_r, g_r, w_d2_r, w_d3_r, w_d4_r, ig_d2_r;
  logic signed [PROD_W-1:0] p1_r, p2_r;
  logic signed [STEP_W-1:0] blr_r, stp_r;
  logic [IN_AW-1:0]         idx1_r, idx2_r, idx3_r, idx4_r;
  logic                     s1_r, s2_r, s3_r, s4_r;
  logic signed [LR_W:0]     lr_s;
  logic signed [DATA_W-1:0] ig_new, w_new, b_new;

  assign lr_s   = $signed({1'b0, lr_r});
  assign ig_new = sat32(SUM_W'(ig_d2_r) + SUM_W'(ACC_W'(p2_r >>> FRAC_BITS)));
  assign w_new  = sat32(SUM_W'(w_d4_r) - SUM_W'(stp_r >>> 16));
  assign b_new  = sat32(SUM_W'(bh_r) - SUM_W'(blr_r >>> 16));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
      s2_r <= 1'b0;
      s3_r <= 1'b0;
      s4_r <= 1'b0;
    end else begin
      s1_r <= (state_r == S_BWALK) && (cnt_r < ni);
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
    end
  end

  always_ff @(posedge clk) begin
    // bias step and dz, ahead of the walk
    if (state_r == S_BPREP && cnt_r == CNT_W'(1)) begin
      dz_r <= (relu_r && $signed(p_rdata) <= 0) ? '0 : item_r.value;
      bh_r <= $signed(b_rdata);
    end
    blr_r   <= dz_r * lr_s;
    // walk over the inputs
    idx1_r  <= cnt_r[IN_AW-1:0];
    p1_r    <= $signed(x_rdata) * dz_r;
    p2_r    <= dz_r * $signed(w_rdata);
    w_d2_r  <= $signed(w_rdata);
    ig_d2_r <= $signed(g_rdata);
    idx2_r  <= idx1_r;
    g_r     <= sat32(SUM_W'(ACC_W'(p1_r >>> FRAC_BITS)));
    w_d3_r  <= w_d2_r;
    idx3_r  <= idx2_r;
    stp_r   <= g_r * lr_s;
    w_d4_r  <= w_d3_r;
    idx4_r  <= idx3_r;
  end

  // datapath controls
  always_comb begin
    w_we      = 1'b0;
    w_waddr   = {in_item.row_index, in_item.col_index};
    w_wdata   = in_item.value;
    b_we      = 1'b0;
    b_waddr   = in_item.col_index;
    b_wdata   = in_item.value;
    p_we      = 1'b0;
    p_waddr   = ej[OUT_AW-1:0];
    p_wdata   = emit_s;
    x_we      = 1'b0;
    x_waddr   = in_item.row_index;
    x_wdata   = in_item.value;
    g_we      = 1'b0;
    g_waddr   = cnt_r[IN_AW-1:0];
    g_wdata   = '0;
    ring_ctrl = '0;
    mac_add   = 1'b0;
    emit_v    = 1'b0;
    rd_v      = 1'b0;

    if (state_r == S_FWD) w_raddr = {item_r.row_index, cnt_r[OUT_AW-1:0]};
    else w_raddr = {cnt_r[IN_AW-1:0], item_r.col_index};
    if (state_r == S_EMIT) b_raddr = cnt_r[OUT_AW-1:0];
    else b_raddr = item_r.col_index;
    x_raddr = cnt_r[IN_AW-1:0];
    if (state_r == S_RD) g_raddr = item_r.row_index;
    else g_raddr = cnt_r[IN_AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_item.operation)
            OP_WR_WEIGHT: w_we = row_ok_in && col_ok_in;
            OP_WR_BIAS:   b_we = col_ok_in;
            OP_FORWARD: begin
              x_we          = row_ok_in;
              ring_ctrl.clr = !fwd_open_r;
            end
            default: ;
          endcase
        end
      end
      S_CLR: g_we = 1'b1;
      S_FWD: begin
        ring_ctrl.shift = (cnt_r >= CNT_W'(2));
        mac_add         = (cnt_r >= CNT_W'(2)) && (fj < CNT_W'(no));
      end
      S_EMIT: begin
        ring_ctrl.shift = (cnt_r >= CNT_W'(1));
        emit_v          = (cnt_r >= CNT_W'(1)) && (ej < CNT_W'(no));
        p_we            = emit_v;
      end
      S_RD: rd_v = (cnt_r == CNT_W'(1));
      S_BPREP: begin
        b_we    = (cnt_r == CNT_W'(3));
        b_waddr = item_r.col_index;
        b_wdata = b_new;
      end
      S_BWALK: begin
        g_we    = s2_r;
        g_waddr = idx2_r;
        g_wdata = ig_new;
        w_we    = s4_r;
        w_waddr = {idx4_r, item_r.col_index};
        w_wdata = w_new;
      end
      default: ;
    endcase
  end

  // result register
  logic      out_strobe_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit_v || rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      out_item_r.kind         <= KIND_GRAD;
      out_item_r.index        <= item_r.row_index;
      out_item_r.result_value <= $signed(g_rdata);
      out_item_r.final_res    <= 1'b1;
    end else begin
      out_item_r.kind         <= KIND_ACT;
      out_item_r.index        <= ej[9:0];
      out_item_r.result_value <= emit_act;
      out_item_r.final_res    <= (ej == CNT_W'(no) - CNT_W'(1));
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // checks
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_EMIT || $past(state_r) == S_RD))
    else $error("result strobe without an emitting state");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !start) |=> (state_r == S_IDLE))
    else $error("left idle without a transaction");

  a_last_act: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.kind == KIND_ACT && out_item.final_res) |=> !out_strobe)
    else $error("result after the last activation");

endmodule
`default_nettype wire

// File: sim/dense_layer_relu_sgd_unit_test.sv
`timescale 1ns / 100ps
module dense_layer_relu_sgd_unit_test;
  import dlrs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  dense_layer_relu_sgd_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  localparam int IDLE_LIMIT = 20000;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint S48_HI = 64'sd140737488355327;
  localparam longint S48_LO = -64'sd140737488355328;

  // shadow of the configuration registers
  logic        relu_on;
  logic [15:0] lrate;
  logic [10:0] in_cnt;
  logic [6:0]  out_cnt;

  // shadow of the layer state
  logic signed [31:0] weights [0:65535];
  logic signed [31:0] biases [0:63];
  logic signed [31:0] inputs_seen [0:1023];
  logic signed [31:0] pre_act [0:63];
  longint             fwd_acc [0:63];
  logic signed [31:0] in_grad [0:1023];
  bit                 fwd_open;
  bit                 bwd_open;

  in_item_t  items_to_send [$];
  out_item_t expected_outputs [$];

  bit took;
  int sent_count;
  int mismatch_cnt;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int active_inputs();
    return (in_cnt == 0) ? 1 : (in_cnt > IN_MAX) ? IN_MAX : int'(in_cnt);
  endfunction

  function automatic int active_outputs();
    return (out_cnt == 0) ? 1 : (out_cnt > OUT_MAX) ? OUT_MAX : int'(out_cnt);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Q15.16 product, floored
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // Advance the layer shadow by one transaction and queue its results.
  function automatic void layer_apply(in_item_t it);
    int        ni;
    int        no;
    longint    s;
    longint    dz;
    longint    g;
    longint    wv;
    out_item_t r;
    ni = active_inputs();
    no = active_outputs();
    case (it.operation)
      OP_WR_WEIGHT: begin
        if (it.row_index < ni && it.col_index < no)
          weights[{it.row_index, it.col_index}] = it.value;
      end
      OP_WR_BIAS: begin
        if (it.col_index < no) biases[it.col_index] = it.value;
      end
      OP_FORWARD: begin
        if (!fwd_open) begin
          for (int j = 0; j < OUT_MAX; j++) fwd_acc[j] = 0;
          fwd_open = 1;
        end
        if (it.row_index < ni) begin
          inputs_seen[it.row_index] = it.value;
          for (int j = 0; j < no; j++)
            fwd_acc[j] = clamp(fwd_acc[j] + qmul(it.value,
                               weights[{it.row_index, 6'(j)}]), S48_LO, S48_HI);
        end
        if (it.last) begin
          fwd_open = 0;
          for (int j = 0; j < no; j++) begin
            s = clamp(fwd_acc[j] + longint'(biases[j]), S32_LO, S32_HI);
            pre_act[j] = 32'(s);
            if (relu_on && s < 0) s = 0;
            r.kind = KIND_ACT;
            r.index = 10'(j);
            r.result_value = 32'(s);
            r.final_res = (j + 1 == no);
            expected_outputs = {expected_outputs, r};
          end
        end
      end
      OP_BACKWARD: begin
        if (!bwd_open) begin
          for (int i = 0; i < IN_MAX; i++) in_grad[i] = 0;
          bwd_open = 1;
        end
        if (it.col_index < no) begin
          dz = it.value;
          if (relu_on && pre_act[it.col_index] <= 0) dz = 0;
          for (int i = 0; i < ni; i++) begin
            wv = weights[{10'(i), it.col_index}];
            g = clamp(qmul(inputs_seen[i], dz), S32_LO, S32_HI);
            in_grad[i] = 32'(clamp(longint'(in_grad[i]) + qmul(dz, wv), S32_LO, S32_HI));
            weights[{10'(i), it.col_index}] =
              32'(clamp(wv - ((g * longint'(lrate)) >>> 16), S32_LO, S32_HI));
          end
          biases[it.col_index] = 32'(clamp(longint'(biases[it.col_index]) -
                                 ((dz * longint'(lrate)) >>> 16), S32_LO, S32_HI));
        end
        if (it.last) bwd_open = 0;
      end
      OP_RD_GRAD: begin
        if (it.row_index < ni) begin
          r.kind = KIND_GRAD;
          r.index = it.row_index;
          r.result_value = in_grad[it.row_index];
          r.final_res = 1'b1;
          expected_outputs = {expected_outputs, r};
        end
      end
      default: ;
    endcase
  endfunction

  // Sample both channels; compare results before predicting this edge's input.
  always @(posedge clk) begin
    took <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_outputs.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: kind %0d index %0d value %0d final %0d",
                     out_item.kind, out_item.index, out_item.result_value,
                     out_item.final_res);
        end else begin
          out_item_t e;
          e = expected_outputs.pop_front();
          if (e.kind !== out_item.kind || e.index !== out_item.index ||
              e.result_value !== out_item.result_value ||
              e.final_res !== out_item.final_res) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected kind %0d index %0d value %0d final %0d, got %0d %0d %0d %0d",
                       e.kind, e.index, e.result_value, e.final_res, out_item.kind,
                       out_item.index, out_item.result_value, out_item.final_res);
          end
        end
      end
      if (start && !busy) layer_apply(in_item);
      // watchdog: count cycles in which no transaction and no result moves
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("dense_layer_relu_sgd_unit_test: errors");
        $finish;
      end
    end
  end

  // Drive on the falling edge: hold an unaccepted transaction, else pull the next.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold
    end else if (items_to_send.size() > 0 &&
                 ((sent_count >= 200 && sent_count < 300) || $urandom_range(0, 99) >= 16)) begin
      in_item <= items_to_send.pop_front();
      start <= 1'b1;
      sent_count++;
    end else begin
      start <= 1'b0;
    end
  end

  task automatic push_item(logic [2:0] op, int row, int col, logic [31:0] v, bit lst);
    in_item_t it;
    it.operation = op;
    it.row_index = 10'(row);
    it.col_index = 6'(col);
    it.value = v;
    it.last = lst;
    items_to_send = {items_to_send, it};
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [15:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    case (idx)
      REG_RELU: relu_on = d[0];
      REG_LRATE: lrate = d;
      REG_IN_COUNT: in_cnt = d[10:0];
      REG_OUT_COUNT: out_cnt = d[6:0];
      default: ;
    endcase
  endtask

  // Wait until everything queued has gone through and the block is idle.
  task automatic drain();
    while (items_to_send.size() != 0 || start || expected_outputs.size() != 0 || busy)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Configure, fill every store that the active sizes can read, then run
  // random forward/backward passes, reads, writes and noise.
  task automatic run_phase(bit relu, int lr, int inc, int outc, int n_random, bit directed);
    int ni;
    int no;
    int k;
    int sel;
    int row;
    int col;
    int pushed;
    drain();
    cfg_write(REG_RELU, 16'(relu));
    cfg_write(REG_LRATE, 16'(lr));
    cfg_write(REG_IN_COUNT, 16'(inc));
    cfg_write(REG_OUT_COUNT, 16'(outc));
    @(negedge clk) cfg_we <= 1'b0;
    ni = active_inputs();
    no = active_outputs();
    for (int r = 0; r < ni; r++)
      for (int c = 0; c < no; c++)
        push_item(OP_WR_WEIGHT, r, c, pick_value(), 0);
    for (int c = 0; c < no; c++) push_item(OP_WR_BIAS, 0, c, pick_value(), 0);
    for (int r = 0; r < ni; r++) push_item(OP_FORWARD, r, 0, pick_value(), r == ni - 1);

    if (directed) begin
      // unknown codes, edges of the index fields and the value extremes
      push_item(3'd5, 1023, 63, 32'hffff_ffff, 1);
      push_item(3'd6, 0, 0, 32'h0, 0);
      push_item(3'd7, 512, 32, 32'h8000_0000, 1);
      push_item(OP_RD_GRAD, 0, 0, 0, 0);
      push_item(OP_RD_GRAD, 1023, 63, 0, 1);
      push_item(OP_WR_WEIGHT, 1023, 63, 32'h7fff_ffff, 0);
      push_item(OP_WR_BIAS, 0, 63, 32'h7fff_ffff, 0);
      push_item(OP_FORWARD, 0, 0, 32'h7fff_ffff, 0);
      push_item(OP_FORWARD, 1, 0, 32'h8000_0000, 0);
      push_item(OP_FORWARD, 1023, 0, 32'h1234_5678, 1);
      push_item(OP_BACKWARD, 0, 63, 32'h0001_0000, 0);
      push_item(OP_BACKWARD, 0, 0, 32'h7fff_ffff, 0);
      push_item(OP_BACKWARD, 0, 1, 32'h8000_0000, 1);
      push_item(OP_RD_GRAD, 0, 0, 0, 0);
      push_item(OP_RD_GRAD, ni - 1, 0, 0, 1);
      push_item(OP_RD_GRAD, ni, 0, 0, 0);
      push_item(OP_FORWARD, 2, 0, 32'h0, 1);
      push_item(OP_BACKWARD, 0, 2, 32'hffff_0000, 1);
    end

    pushed = 0;
    while (pushed < n_random) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        k = $urandom_range(1, (ni + 2 > 6) ? 6 : ni + 2);
        for (int e = 0; e < k; e++) begin
          row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, ni - 1);
          push_item(OP_FORWARD, row, $urandom_range(0, 63), pick_value(), e == k - 1);
        end
        pushed += k;
      end else if (sel < 60) begin
        // wide layers make each backward element long: keep those passes short
        k = (ni > 64) ? 1 : $urandom_range(1, 4);
        for (int e = 0; e < k; e++) begin
          col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, no - 1);
          push_item(OP_BACKWARD, $urandom_range(0, 1023), col, pick_value(), e == k - 1);
        end
        pushed += k;
      end else if (sel < 75) begin
        row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, ni - 1);
        push_item(OP_RD_GRAD, row, $urandom_range(0, 63), $urandom, $urandom_range(0, 1));
        pushed++;
      end else if (sel < 85) begin
        row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, ni - 1);
        col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, no - 1);
        push_item(OP_WR_WEIGHT, row, col, pick_value(), $urandom_range(0, 1));
        pushed++;
      end else if (sel < 92) begin
        col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, no - 1);
        push_item(OP_WR_BIAS, $urandom_range(0, 1023), col, pick_value(), $urandom_range(0, 1));
        pushed++;
      end else begin
        // ignored codes: do not count them
        push_item(3'($urandom_range(5, 7)), $urandom_range(0, 1023), $urandom_range(0, 63),
                  $urandom, $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_RELU;
    cfg_wdata = '0;
    relu_on = 1'b1;
    lrate = 16'd66;
    in_cnt = 11'd1024;
    out_cnt = 7'd64;
    for (int j = 0; j < OUT_MAX; j++) fwd_acc[j] = 0;
    for (int i = 0; i < IN_MAX; i++) in_grad[i] = 0;
    fwd_open = 0;
    bwd_open = 0;
    took = 0;
    sent_count = 0;
    mismatch_cnt = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    run_phase(1, 66, 8, 4, 30, 1);
    run_phase(0, 65535, 0, 127, 20, 0);                 // widths act as 1 and 64
    run_phase(1, 0, 5, 0, 25, 0);
    run_phase(1, $urandom_range(0, 65535), 6, 4, 30, 0);
    run_phase(1, $urandom_range(0, 65535), $urandom_range(2, 6), $urandom_range(2, 6), 20, 0);
    drain();
    repeat (200) @(posedge clk);

    if (mismatch_cnt == 0 && expected_outputs.size() == 0) begin
      $display("dense_layer_relu_sgd_unit_test: clean");
    end else begin
      $display("dense_layer_relu_sgd_unit_test: errors");
    end
    $finish;
  end

endmodule
